// ===== rtl/core/dret_pkg.sv =====
// ----------------------------------------------------------------------------
// dret_pkg
// shared types and constants for the difficulty retarget block
// ----------------------------------------------------------------------------
package dret_pkg;

  localparam int unsigned NUM_CFG    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [31:0] HEIGHT_FULL = 32'd10000;
  localparam logic [31:0] HEIGHT_HALF = 32'd5000;

  localparam logic [1:0] CFG_LIMIT0 = 2'd0;
  localparam logic [1:0] CFG_LIMIT1 = 2'd1;
  localparam logic [1:0] CFG_LIMIT2 = 2'd2;
  localparam logic [1:0] CFG_LIMIT3 = 2'd3;

  // classified item handed from front to back
  typedef struct packed {
    logic [31:0]  span;     // clamped span, fits 26 bits
    logic [23:0]  tspan;
    logic [255:0] target;   // expanded last target
  } work_t;

  typedef struct packed {
    logic         new_rule;
    logic [23:0]  target_span;
    logic [30:0]  last_height;
    logic [31:0]  last_bits;
    logic [39:0]  last_time;
    logic [39:0]  first_time;
  } in_item_t;

  typedef struct packed {
    logic [31:0] new_bits;
  } out_item_t;

endpackage

// ===== rtl/core/dret_if.sv =====
// ----------------------------------------------------------------------------
// dret_if
// valid/ready channel carrying one word of type T
// ----------------------------------------------------------------------------
interface dret_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/dret_front.sv =====
// ----------------------------------------------------------------------------
// dret_front
// computes clamp bounds, clamps the span and expands the compact target
// ----------------------------------------------------------------------------
module dret_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dret_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dret_pkg::work_t       out_data
);
  // stage 1: bounds and span difference
  logic        s1_valid;
  logic [27:0] s1_lo, s1_hi;
  logic [40:0] s1_diff;
  logic [23:0] s1_tspan;
  logic [31:0] s1_bits;

  logic [25:0] t26, q26, lo_b, hi_b, lo_r;
  logic [31:0] nh;

  always_comb begin
    t26  = {2'b00, in_data.target_span};
    q26  = t26 >> 2;
    lo_b = in_data.new_rule ? (t26 - q26) : q26;
    hi_b = in_data.new_rule ? (t26 + q26) : (t26 << 2);
    nh   = {1'b0, in_data.last_height} + 32'd1;
    lo_r = lo_b;
    if (nh <= dret_pkg::HEIGHT_FULL) begin
      lo_r = (nh > dret_pkg::HEIGHT_HALF) ? (lo_b >> 1) : (lo_b >> 2);
    end
  end

  logic s1_adv;
  assign s1_adv   = !s1_valid || !out_valid || out_ready;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_valid;
    end
    if (s1_adv && in_valid) begin
      s1_lo    <= {2'b00, lo_r};
      s1_hi    <= {2'b00, hi_b};
      s1_diff  <= {1'b0, in_data.last_time} - {1'b0, in_data.first_time};
      s1_tspan <= in_data.target_span;
      s1_bits  <= in_data.last_bits;
    end
  end

  // stage 2: clamp and decode
  logic [40:0]  lo41, hi41;
  logic [27:0]  span_c;
  logic [7:0]   sz;
  logic [255:0] dec;
  logic [22:0]  mant;

  always_comb begin
    lo41 = {13'd0, s1_lo};
    hi41 = {13'd0, s1_hi};
    if (!s1_diff[40] && s1_diff > hi41) begin
      span_c = s1_hi;
    end else if (s1_diff[40] || s1_diff < lo41) begin
      span_c = s1_lo;
    end else begin
      span_c = s1_diff[27:0];
    end
    sz   = s1_bits[31:24];
    mant = s1_bits[22:0];
    if (sz <= 8'd3) begin
      dec = {233'd0, mant} >> ({5'd0, 8'd3 - sz} << 3);
    end else begin
      dec = {233'd0, mant} << ({3'd0, sz - 8'd3} << 3);
    end
  end

  logic s2_stall;
  assign s2_stall = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!s2_stall) begin
      out_valid <= s1_valid;
    end
    if (!s2_stall && s1_valid) begin
      out_data.span   <= {4'd0, span_c};
      out_data.tspan  <= s1_tspan;
      out_data.target <= dec;
    end
  end
endmodule

// ===== rtl/core/dret_fifo.sv =====
// ----------------------------------------------------------------------------
// dret_fifo
// short queue between front and back
// ----------------------------------------------------------------------------
module dret_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dret_pkg::work_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output dret_pkg::work_t out_data
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  dret_pkg::work_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic push, pop;

  assign in_ready  = cnt < (AW+1)'(DEPTH);
  assign out_valid = cnt != '0;
  assign out_data  = mem[rp];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) begin
      mem[wp] <= in_data;
    end
  end
endmodule

// ===== rtl/core/dret_back.sv =====
// ----------------------------------------------------------------------------
// dret_back
// pipelined multiply by span, division by target span, cap and compact encode
// ----------------------------------------------------------------------------
module dret_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [255:0]         limit,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dret_pkg::work_t      in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dret_pkg::out_item_t  out_data
);
  // stages: 8 multiply limbs, 256 restoring division steps, cap, encode
  localparam int unsigned NMUL = 8;
  localparam int unsigned NDIV = 256;
  localparam int unsigned NST  = NMUL + NDIV + 2;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic [NST-1:0] vld;

  // multiply pipeline: one 32x32 limb product per stage
  logic [255:0] m_acc  [NMUL+1];
  logic [255:0] m_src  [NMUL+1];
  logic [31:0]  m_car  [NMUL+1];
  logic [31:0]  m_span [NMUL+1];
  logic [23:0]  m_t    [NMUL+1];

  always_comb begin
    m_acc[0]  = '0;
    m_src[0]  = in_data.target;
    m_car[0]  = '0;
    m_span[0] = in_data.span;
    m_t[0]    = in_data.tspan;
  end

  for (genvar i = 0; i < NMUL; i++) begin : g_mul
    logic [63:0]  p;
    logic [255:0] acc_n;
    assign p = {32'd0, m_src[i][32*i +: 32]} * {32'd0, m_span[i]} + {32'd0, m_car[i]};
    always_comb begin
      acc_n = m_acc[i];
      acc_n[32*i +: 32] = p[31:0];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        m_acc[i+1]  <= acc_n;
        m_car[i+1]  <= p[63:32];
        m_src[i+1]  <= m_src[i];
        m_span[i+1] <= m_span[i];
        m_t[i+1]    <= m_t[i];
      end
    end
  end

  // restoring division, one quotient bit per stage, msb first
  logic [255:0] d_num [NDIV+1];
  logic [23:0]  d_rem [NDIV+1];
  logic [23:0]  d_t   [NDIV+1];

  always_comb begin
    d_num[0] = m_acc[NMUL];
    d_rem[0] = '0;
    d_t[0]   = m_t[NMUL];
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic [24:0] tr;
    logic        ge;
    assign tr = {d_rem[k], d_num[k][255]};
    assign ge = tr >= {1'b0, d_t[k]};
    always_ff @(posedge clk) begin
      if (adv) begin
        d_rem[k+1] <= ge ? 24'(tr - {1'b0, d_t[k]}) : tr[23:0];
        d_num[k+1] <= {d_num[k][254:0], ge};
        d_t[k+1]   <= d_t[k];
      end
    end
  end

  // zero divisor gives all ones naturally: every step compares against zero
  logic [255:0] capped;
  always_ff @(posedge clk) begin
    if (adv) begin
      capped <= (d_num[NDIV] > limit) ? limit : d_num[NDIV];
    end
  end

  // encode
  logic [8:0]   nbits;
  logic [5:0]   size;
  logic [255:0] sh;
  logic [31:0]  comp;
  logic [6:0]   size_f;
  always_comb begin
    nbits = '0;
    for (int b = 0; b < 256; b++) begin
      if (capped[b]) begin
        nbits = 9'(b + 1);
      end
    end
    size = 6'((nbits + 9'd7) >> 3);
    if (size <= 6'd3) begin
      sh = capped << ({3'd0, 6'd3 - size} << 3);
    end else begin
      sh = capped >> ({3'd0, size - 6'd3} << 3);
    end
    comp   = sh[31:0];
    size_f = {1'b0, size};
    if (comp[23]) begin
      comp   = comp >> 8;
      size_f = size_f + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
    if (adv) begin
      out_data.new_bits <= {1'b0, size_f, 1'b0, comp[22:0]};
    end
  end
  assign out_valid = vld[NST-1];
endmodule

// ===== rtl/core/difficulty_retarget_top.sv =====
// ----------------------------------------------------------------------------
// difficulty_retarget_top
// next compact target from a retarget window, capped at a programmable limit
// ----------------------------------------------------------------------------
// channel  dir  fields
// in       in   new_rule target_span last_height last_bits last_time first_time
// out      out  new_bits
// cfg      in   cfg_we cfg_idx cfg_data (limit words 0..3)
//
// one item per cycle while out is taken; items pass the front's bounds and clamp
// stages, the queue, and 266 back stages (8 limb multiplies, 256 division steps, cap, encode).
// reset is synchronous and loads the default limit.
// the back pipeline stalls as one when out is not taken; the queue lets the
// front keep taking items meanwhile, until the queue is full.
module difficulty_retarget_top #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dret_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dret_pkg::CFG_DATA_W-1:0] cfg_data,
  dret_if.sink                            in,
  dret_if.source                          out
);
  logic [63:0] limit_w [dret_pkg::NUM_CFG];

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_w[0] <= 64'hFFFF_FFFF_FFFF_FFFF;
      limit_w[1] <= 64'hFFFF_FFFF_FFFF_FFFF;
      limit_w[2] <= 64'hFFFF_FFFF_FFFF_FFFF;
      limit_w[3] <= 64'h0000_0FFF_FFFF_FFFF;
    end else if (cfg_we) begin
      case (cfg_idx)
        dret_pkg::CFG_LIMIT0: limit_w[0] <= cfg_data;
        dret_pkg::CFG_LIMIT1: limit_w[1] <= cfg_data;
        dret_pkg::CFG_LIMIT2: limit_w[2] <= cfg_data;
        dret_pkg::CFG_LIMIT3: limit_w[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic            f_valid, f_ready, b_valid, b_ready;
  dret_pkg::work_t f_data, b_data;

  dret_front u_front (
    .clk, .rst,
    .in_valid (in.valid), .in_ready (in.ready), .in_data (in.data),
    .out_valid (f_valid), .out_ready (f_ready), .out_data (f_data)
  );

  dret_fifo #(.DEPTH (QDEPTH)) u_fifo (
    .clk, .rst,
    .in_valid (f_valid), .in_ready (f_ready), .in_data (f_data),
    .out_valid (b_valid), .out_ready (b_ready), .out_data (b_data)
  );

  dret_back u_back (
    .clk, .rst,
    .limit ({limit_w[3], limit_w[2], limit_w[1], limit_w[0]}),
    .in_valid (b_valid), .in_ready (b_ready), .in_data (b_data),
    .out_valid (out.valid), .out_ready (out.ready), .out_data (out.data)
  );
endmodule
